// ----- rtl/hlsp_pkg.sv -----
package hlsp_pkg;

  localparam int MAX_NODES_DEF   = 128;
  localparam int MAX_HOPS_DEF    = 128;
  localparam int QUEUE_DEPTH_DEF = 4096;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int          COST_W   = 31;
  localparam logic [30:0] COST_MAX = 31'h7FFF_FFFF;

  // request function codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NO_PATH   = 3'd2;
  localparam logic [2:0] ST_LIST_FULL = 3'd3;
  localparam logic [2:0] ST_Q_OVF     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_DEST       = 2'd2;
  localparam logic [1:0] CFG_MAX_STOPS  = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } q_cmd_t;

  typedef struct packed {
    logic done;
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/hlsp_queue.sv -----
// Sorted queue in a circular buffer; insertion shifts larger entries up one
// slot per cycle, so equal costs keep arrival order.
module hlsp_queue import hlsp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NODE_W      = 7,
  parameter int HOP_W       = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_cmd_t            cmd,
  input  logic [COST_W-1:0] push_cost,
  input  logic [NODE_W-1:0] push_node,
  input  logic [HOP_W-1:0]  push_hops,
  output q_stat_t           stat,
  output logic [COST_W-1:0] pop_cost,
  output logic [NODE_W-1:0] pop_node,
  output logic [HOP_W-1:0]  pop_hops
);

  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int ENT_W  = COST_W + NODE_W + HOP_W;

  typedef enum logic [1:0] {Q_IDLE, Q_PCMP, Q_PWR, Q_POP} q_state_t;

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];

  q_state_t          state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [QA_W-1:0]   head_r, head_nxt;
  logic [FILL_W-1:0] pos_r, pos_nxt;
  logic [ENT_W-1:0]  new_r, new_nxt;
  logic [ENT_W-1:0]  pop_r, pop_nxt;
  logic              done_r, done_nxt;
  logic [ENT_W-1:0]  rd_r;

  logic              we, re;
  logic [QA_W-1:0]   wa, ra;
  logic [ENT_W-1:0]  wd;

  function automatic logic [QA_W-1:0] slot(input logic [QA_W-1:0] head,
                                           input logic [FILL_W-1:0] i);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(i);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[QA_W-1:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    head_nxt  = head_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    pop_nxt   = pop_r;
    done_nxt  = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    wa        = '0;
    ra        = '0;
    wd        = new_r;
    case (state_r)
      Q_IDLE: begin
        if (cmd.flush) begin
          fill_nxt = '0;
          head_nxt = '0;
        end else if (cmd.push) begin
          new_nxt = {push_cost, push_node, push_hops};
          if (fill_r == '0) begin
            we       = 1'b1;
            wa       = head_r;
            wd       = {push_cost, push_node, push_hops};
            fill_nxt = fill_r + 1'b1;
            done_nxt = 1'b1;
          end else begin
            re        = 1'b1;
            ra        = slot(head_r, fill_r - 1'b1);
            pos_nxt   = fill_r;
            state_nxt = Q_PCMP;
          end
        end else if (cmd.pop) begin
          re        = 1'b1;
          ra        = head_r;
          state_nxt = Q_POP;
        end
      end
      Q_PCMP: begin
        we = 1'b1;
        wa = slot(head_r, pos_r);
        if (rd_r[ENT_W-1 -: COST_W] > new_r[ENT_W-1 -: COST_W]) begin
          wd      = rd_r;
          pos_nxt = pos_r - 1'b1;
          if (pos_r == FILL_W'(1)) begin
            state_nxt = Q_PWR;
          end else begin
            re = 1'b1;
            ra = slot(head_r, pos_r - FILL_W'(2));
          end
        end else begin
          fill_nxt  = fill_r + 1'b1;
          done_nxt  = 1'b1;
          state_nxt = Q_IDLE;
        end
      end
      Q_PWR: begin
        we        = 1'b1;
        wa        = slot(head_r, pos_r);
        fill_nxt  = fill_r + 1'b1;
        done_nxt  = 1'b1;
        state_nxt = Q_IDLE;
      end
      Q_POP: begin
        pop_nxt   = rd_r;
        head_nxt  = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_nxt  = fill_r - 1'b1;
        done_nxt  = 1'b1;
        state_nxt = Q_IDLE;
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      fill_r  <= '0;
      head_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      head_r  <= head_nxt;
      done_r  <= done_nxt;
    end
    pos_r <= pos_nxt;
    new_r <= new_nxt;
    pop_r <= pop_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign stat.done  = done_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign pop_cost   = pop_r[ENT_W-1 -: COST_W];
  assign pop_node   = pop_r[HOP_W +: NODE_W];
  assign pop_hops   = pop_r[HOP_W-1:0];

endmodule

// ----- rtl/hop_limited_shortest_path_unit.sv -----
// Hop-limited shortest path unit.
// Input channel (in_valid / in_stall): one request per item. func selects
// add edge, search or clear edge lists; other codes give no path. Result
// channel (out_valid / out_stall): exactly one result per request, in request order.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (node count,
// source, destination, max stops); write only while the unit is idle.
// An add edge passes S_EDGE and S_DONE to the output register, a clear
// S_DONE alone. A search first sweeps min(node_count, MAX_NODES) *
// MAX_HOPS cost-table entries, one per cycle, then runs Dijkstra: each
// pop passes S_LOOP and S_POP_W, then S_DEG for the degree read; each
// edge scanned passes S_ADJ_RD, S_ADJ and S_CELL; each push waits in
// S_PUSH_W while the queue shifts larger entries. in_stall is held for the whole search.
// Throughput: one request at a time; the next request is taken while a
// result still waits in the output register.
// Reset: synchronous, active low. After reset the cost table is swept to
// the maximum cost, MAX_NODES * MAX_HOPS entries (16384 by default), with
// in_stall high; config writes are taken during that sweep.
// A stalled result holds in the output register; a finished request waits
// for it before loading the next result.
module hop_limited_shortest_path_unit import hlsp_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_HOPS    = MAX_HOPS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [6:0]  in_edge_from,
  input  logic [6:0]  in_edge_to,
  input  logic [15:0] in_edge_price,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [30:0] out_path_cost,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int NB    = $clog2(MAX_NODES);      // node index bits
  localparam int HB    = $clog2(MAX_HOPS);       // hop index bits
  localparam int DB    = $clog2(MAX_NODES + 1);  // degree / row count bits
  localparam int ADJ_W = NB + WEIGHT_BITS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EDGE, S_CLR, S_START, S_SEED, S_LOOP, S_POP_W,
    S_DEG, S_ADJ_RD, S_ADJ, S_CELL, S_PUSH_W, S_DONE
  } state_t;

  // storage: adjacency {target, weight}, out degree, best cost per (node, hops)
  logic [ADJ_W-1:0]  adj_mem  [MAX_NODES << NB];
  logic [DB-1:0]     deg_mem  [MAX_NODES];
  logic [COST_W-1:0] cost_mem [MAX_NODES << HB];

  state_t            state_r, state_nxt;
  logic [7:0]        node_count_r;
  logic [6:0]        source_r, dest_r, max_stops_r;
  logic [MAX_NODES-1:0] deg_vld_r, deg_vld_nxt;

  logic [6:0]        from_r, from_nxt, to_r, to_nxt;
  logic [WEIGHT_BITS-1:0] price_r, price_nxt;
  logic [NB-1:0]     row_r, row_nxt;
  logic [HB-1:0]     hop_r, hop_nxt;
  logic [DB-1:0]     rows_r, rows_nxt;
  logic [NB-1:0]     u_r, u_nxt, v_r, v_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt, sum_r, sum_nxt;
  logic [HB-1:0]     nh_r, nh_nxt;
  logic [DB-1:0]     deg_r, deg_nxt, idx_r, idx_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  logic [COST_W-1:0] res_cost_r, res_cost_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;

  // memory ports
  logic              adj_we, adj_re;
  logic [2*NB-1:0]   adj_wa, adj_ra;
  logic [ADJ_W-1:0]  adj_wd, adj_rd_r;
  logic              deg_we, deg_re;
  logic [NB-1:0]     deg_wa, deg_ra;
  logic [DB-1:0]     deg_wd, deg_rd_r;
  logic              deg_rv_r;
  logic              cost_we, cost_re;
  logic [NB+HB-1:0]  cost_wa, cost_ra;
  logic [COST_W-1:0] cost_wd, cost_rd_r;

  q_cmd_t            q_cmd;
  q_stat_t           q_stat;
  logic [COST_W-1:0] q_pop_cost;
  logic [NB-1:0]     q_pop_node;
  logic [HB-1:0]     q_pop_hops;

  logic [DB-1:0]     cur_deg;
  logic [COST_W:0]   raw_sum;
  logic              edge_bad;

  hlsp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NODE_W      (NB),
    .HOP_W       (HB)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .push_cost (sum_r),
    .push_node (v_r),
    .push_hops (nh_r),
    .stat      (q_stat),
    .pop_cost  (q_pop_cost),
    .pop_node  (q_pop_node),
    .pop_hops  (q_pop_hops)
  );

  assign in_stall = (state_r != S_IDLE);
  assign cur_deg  = deg_rv_r ? deg_rd_r : '0;
  assign edge_bad = (int'(from_r) >= MAX_NODES) || (int'(to_r) >= MAX_NODES) ||
                    (int'(cur_deg) >= MAX_NODES);
  // cost + weight with a carry bit; S_ADJ saturates it to COST_MAX
  assign raw_sum  = {1'b0, cost_r} + (COST_W + 1)'(adj_rd_r[WEIGHT_BITS-1:0]);

  always_comb begin
    state_nxt      = state_r;
    deg_vld_nxt    = deg_vld_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    price_nxt      = price_r;
    row_nxt        = row_r;
    hop_nxt        = hop_r;
    rows_nxt       = rows_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    cost_nxt       = cost_r;
    sum_nxt        = sum_r;
    nh_nxt         = nh_r;
    deg_nxt        = deg_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_cost_nxt   = res_cost_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_cost_nxt   = out_cost_r;
    adj_we = 1'b0; adj_re = 1'b0; adj_wa = '0; adj_ra = '0; adj_wd = '0;
    deg_we = 1'b0; deg_re = 1'b0; deg_wa = '0; deg_ra = '0; deg_wd = '0;
    cost_we = 1'b0; cost_re = 1'b0; cost_wa = '0; cost_ra = '0; cost_wd = COST_MAX;
    q_cmd = '0;

    case (state_r)
      S_INIT, S_CLR: begin
        // sweep rows x hops to the maximum cost
        cost_we = 1'b1;
        cost_wa = {row_r, hop_r};
        cost_wd = COST_MAX;
        if (hop_r == HB'(MAX_HOPS - 1)) begin
          hop_nxt = '0;
          row_nxt = row_r + 1'b1;
          if (DB'(row_r) == rows_r - 1'b1) begin
            state_nxt = (state_r == S_INIT) ? S_IDLE : S_START;
          end
        end else begin
          hop_nxt = hop_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          from_nxt       = in_edge_from;
          to_nxt         = in_edge_to;
          price_nxt      = WEIGHT_BITS'(in_edge_price);
          res_cost_nxt   = '0;
          deg_re         = 1'b1;
          deg_ra         = NB'(in_edge_from);
          case (in_func)
            FUNC_ADD: state_nxt = S_EDGE;
            FUNC_SEARCH: begin
              rows_nxt = (int'(node_count_r) >= MAX_NODES) ? DB'(MAX_NODES)
                                                           : DB'(node_count_r);
              row_nxt  = '0;
              hop_nxt  = '0;
              state_nxt = (node_count_r == 8'd0) ? S_START : S_CLR;
            end
            FUNC_CLEAR: begin
              deg_vld_nxt    = '0;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_DONE;
            end
            default: begin
              res_status_nxt = ST_NO_PATH;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_EDGE: begin
        if (edge_bad) begin
          res_status_nxt = ST_LIST_FULL;
        end else begin
          adj_we = 1'b1;
          adj_wa = {NB'(from_r), NB'(cur_deg)};
          adj_wd = {NB'(to_r), price_r};
          deg_we = 1'b1;
          deg_wa = NB'(from_r);
          deg_wd = cur_deg + 1'b1;
          deg_vld_nxt[NB'(from_r)] = 1'b1;
          res_status_nxt = ST_ADDED;
        end
        state_nxt = S_DONE;
      end
      S_START: begin
        q_cmd.flush = 1'b1;
        if (int'(source_r) >= MAX_NODES) begin
          res_status_nxt = ST_NO_PATH;
          state_nxt      = S_DONE;
        end else begin
          cost_we   = 1'b1;
          cost_wa   = {NB'(source_r), HB'(0)};
          cost_wd   = '0;
          sum_nxt   = '0;
          v_nxt     = NB'(source_r);
          nh_nxt    = '0;
          deg_nxt   = '0;  // after the seed push the edge scan ends at once
          idx_nxt   = '0;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        q_cmd.push = 1'b1;
        state_nxt  = S_PUSH_W;
      end
      S_LOOP: begin
        if (q_stat.empty) begin
          res_status_nxt = ST_NO_PATH;
          state_nxt      = S_DONE;
        end else begin
          q_cmd.pop = 1'b1;
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        if (q_stat.done) begin
          u_nxt    = q_pop_node;
          cost_nxt = q_pop_cost;
          if (int'(q_pop_node) == int'(dest_r)) begin
            res_status_nxt = ST_FOUND;
            res_cost_nxt   = q_pop_cost;
            state_nxt      = S_DONE;
          end else if ((int'(q_pop_hops) > int'(max_stops_r)) ||
                       (int'(q_pop_hops) + 1 >= MAX_HOPS)) begin
            state_nxt = S_LOOP;
          end else begin
            nh_nxt    = q_pop_hops + 1'b1;
            deg_re    = 1'b1;
            deg_ra    = q_pop_node;
            state_nxt = S_DEG;
          end
        end
      end
      S_DEG: begin
        deg_nxt   = cur_deg;
        idx_nxt   = '0;
        state_nxt = S_ADJ_RD;
      end
      S_ADJ_RD: begin
        if (idx_r >= deg_r) begin
          state_nxt = S_LOOP;
        end else begin
          adj_re    = 1'b1;
          adj_ra    = {u_r, NB'(idx_r)};
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        v_nxt     = adj_rd_r[ADJ_W-1 -: NB];
        sum_nxt   = raw_sum[COST_W] ? COST_MAX : raw_sum[COST_W-1:0];
        cost_re   = 1'b1;
        cost_ra   = {adj_rd_r[ADJ_W-1 -: NB], nh_r};
        state_nxt = S_CELL;
      end
      S_CELL: begin
        // read-modify-write of one cost entry; the next cost read waits for S_ADJ
        if (sum_r < cost_rd_r) begin
          cost_we = 1'b1;
          cost_wa = {v_r, nh_r};
          cost_wd = sum_r;
          if (q_stat.full) begin
            res_status_nxt = ST_Q_OVF;
            state_nxt      = S_DONE;
          end else begin
            q_cmd.push = 1'b1;
            state_nxt  = S_PUSH_W;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ADJ_RD;
        end
      end
      S_PUSH_W: begin
        if (q_stat.done) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_ADJ_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_cost_nxt   = (res_status_r == ST_FOUND) ? res_cost_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      node_count_r <= 8'd128;
      source_r     <= '0;
      dest_r       <= '0;
      max_stops_r  <= '0;
      deg_vld_r    <= '0;
      out_valid_r  <= 1'b0;
      row_r        <= '0;
      hop_r        <= '0;
      rows_r       <= DB'(MAX_NODES);
    end else begin
      state_r     <= state_nxt;
      deg_vld_r   <= deg_vld_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      hop_r       <= hop_nxt;
      rows_r      <= rows_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NODE_COUNT: node_count_r <= cfg_wdata;
          CFG_SOURCE:     source_r     <= cfg_wdata[6:0];
          CFG_DEST:       dest_r       <= cfg_wdata[6:0];
          CFG_MAX_STOPS:  max_stops_r  <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    price_r      <= price_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    cost_r       <= cost_nxt;
    sum_r        <= sum_nxt;
    nh_r         <= nh_nxt;
    deg_r        <= deg_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_cost_r   <= res_cost_nxt;
    out_status_r <= out_status_nxt;
    out_cost_r   <= out_cost_nxt;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (deg_re) begin
      deg_rd_r <= deg_mem[deg_ra];
      deg_rv_r <= deg_vld_r[deg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    if (cost_re) begin
      cost_rd_r <= cost_mem[cost_ra];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_path_cost = out_cost_r;

endmodule

// ----- rtl/hlsp_checker.sv -----
module hlsp_checker import hlsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [30:0] out_path_cost
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_path_cost))
    else $error("stalled result changed");

  // only defined status codes leave the unit
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_CLEARED))
    else $error("undefined status code");

  // cost is zero unless a path was found
  a_cost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND) |-> (out_path_cost == '0))
    else $error("nonzero cost without a path");

  // the cost-table sweep after reset keeps requests out; only its start is checked
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during reset sweep");

endmodule

bind hop_limited_shortest_path_unit hlsp_checker u_hlsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_path_cost (out_path_cost)
);
